// File: sv/tps_pkg.sv
// Shared types and constants for the timer prescaler / period splitter.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package tps_pkg;

    localparam int DW      = 32;              // operand width of divider and root
    localparam int DIV_CW  = $clog2(DW);      // divider step counter width
    localparam int ROOT_W  = DW / 2;          // root width
    localparam int SQ_CW   = $clog2(ROOT_W);  // root step counter width

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_ZERO     = 2'd1;
    localparam logic [1:0] STATUS_TOO_HIGH = 2'd2;
    localparam logic [1:0] STATUS_NO_SPLIT = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_TOTAL,
        ST_SQRT,
        ST_DIV_PER,
        ST_DIV_CEIL,
        ST_DIV_PER2,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic          done;
        logic [DW-1:0] quotient;
        logic [DW-1:0] remainder;
    } div_res_t;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } sqrt_res_t;

endpackage
`default_nettype wire

// File: sv/tps_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on tps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tps_div (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    start,
    input  wire logic [tps_pkg::DW-1:0]  dividend,
    input  wire logic [tps_pkg::DW-1:0]  divisor,
    output tps_pkg::div_res_t            res
);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [tps_pkg::DIV_CW-1:0]   cnt_reg, cnt_next;
    logic [tps_pkg::DW-1:0]       quo_reg, quo_next;
    logic [tps_pkg::DW-1:0]       rem_reg, rem_next;
    logic [tps_pkg::DW-1:0]       dsr_reg, dsr_next;
    logic [tps_pkg::DW:0]         shifted;
    logic [tps_pkg::DW+1:0]       diff;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        shifted   = {rem_reg, quo_reg[tps_pkg::DW-1]};
        diff      = {1'b0, shifted} - {2'b00, dsr_reg};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            // trial subtract; keep the difference when it did not borrow
            if (!diff[tps_pkg::DW+1]) begin
                rem_next = diff[tps_pkg::DW-1:0];
            end else begin
                rem_next = shifted[tps_pkg::DW-1:0];
            end
            quo_next = {quo_reg[tps_pkg::DW-2:0], ~diff[tps_pkg::DW+1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == tps_pkg::DIV_CW'(tps_pkg::DW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign res.done      = done_reg;
    assign res.quotient  = quo_reg;
    assign res.remainder = rem_reg;

endmodule
`default_nettype wire

// File: sv/tps_sqrt.sv
// Digit-serial integer square root, two radicand bits per cycle.
// Depends on tps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tps_sqrt (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    start,
    input  wire logic [tps_pkg::DW-1:0]  radicand,
    output tps_pkg::sqrt_res_t           res
);

    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [tps_pkg::SQ_CW-1:0]        cnt_reg, cnt_next;
    logic [tps_pkg::DW-1:0]           x_reg, x_next;
    logic [tps_pkg::ROOT_W:0]         rem_reg, rem_next;
    logic [tps_pkg::ROOT_W-1:0]       root_reg, root_next;
    logic [tps_pkg::ROOT_W+2:0]       rem_sh;
    logic [tps_pkg::ROOT_W+2:0]       trial;
    logic [tps_pkg::ROOT_W+3:0]       diff;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        rem_sh    = {rem_reg, x_reg[tps_pkg::DW-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        diff      = {1'b0, rem_sh} - {1'b0, trial};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            x_next    = radicand;
            rem_next  = '0;
            root_next = '0;
        end else if (busy_reg) begin
            // remainder stays below 2*root+1, so it fits ROOT_W+1 bits
            if (!diff[tps_pkg::ROOT_W+3]) begin
                rem_next  = diff[tps_pkg::ROOT_W:0];
                root_next = {root_reg[tps_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh[tps_pkg::ROOT_W:0];
                root_next = {root_reg[tps_pkg::ROOT_W-2:0], 1'b0};
            end
            x_next   = {x_reg[tps_pkg::DW-3:0], 2'b00};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == tps_pkg::SQ_CW'(tps_pkg::ROOT_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        x_reg    <= x_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign res.done = done_reg;
    assign res.root = root_reg;

endmodule
`default_nettype wire

// File: sv/timer_prescaler_period_split_top.sv
// Work per request: a zero request goes straight to the result; a request that
// is too high takes one division; a normal split takes a division, a root and
// a division; an overflowing period adds two more divisions (serial divider,
// serial root). Throughput: one request at a time; next request taken once
// the result is in the output register. Reset: synchronous active-low
// aresetn, clears control state and clock_freq to 0.
// Sequencer for the splitter; depends on tps_pkg, tps_div, tps_sqrt.
`timescale 1ns / 1ps
`default_nettype none
module timer_prescaler_period_split_top #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,   // clock_freq
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,       // [31:0] target_freq
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,       // [15:0] prescaler_reg, [31:16] reload_reg
    output logic [1:0]       m_tuser        // [1:0] status
);

    localparam logic [32:0] CNT_MAX = (33'd1 << COUNT_BITS) - 33'd1;

    tps_pkg::state_t      state_reg, state_next;
    logic [31:0]          clk_freq_reg;
    logic [31:0]          total_reg, total_next;
    logic [31:0]          pre_reg, pre_next;
    logic [31:0]          per_reg, per_next;
    logic [1:0]           stat_reg, stat_next;
    logic                 m_valid_reg, m_valid_next;
    logic [15:0]          m_pre_reg, m_pre_next;
    logic [15:0]          m_rel_reg, m_rel_next;
    logic [1:0]           m_stat_reg, m_stat_next;

    logic                 div_start;
    logic [31:0]          div_a, div_b;
    logic                 sq_start;
    tps_pkg::div_res_t    div_res;
    tps_pkg::sqrt_res_t   sq_res;

    logic [31:0]          root_clamp;
    logic [31:0]          ceil_q;
    logic [31:0]          per_fix;
    logic [31:0]          pre_m1, per_m1;
    logic                 out_free;

    tps_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .res      (div_res)
    );

    tps_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand (div_res.quotient),
        .res      (sq_res)
    );

    assign out_free   = !m_valid_reg || m_tready;
    // root of a nonzero total is at least 1, so only the upper clamp is needed
    assign root_clamp = ({17'd0, sq_res.root} > CNT_MAX) ? CNT_MAX[31:0]
                                                          : {16'd0, sq_res.root};
    assign ceil_q     = div_res.quotient + {31'd0, (div_res.remainder != 32'd0)};
    assign per_fix    = (per_reg == 32'd0) ? 32'd1 : per_reg;
    assign pre_m1     = pre_reg - 32'd1;
    assign per_m1     = per_fix - 32'd1;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tps_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = (s_tdata == 32'd0) ? tps_pkg::ST_FINISH
                                                    : tps_pkg::ST_DIV_TOTAL;
                end
            end
            tps_pkg::ST_DIV_TOTAL: begin
                if (div_res.done) begin
                    state_next = (div_res.quotient == 32'd0) ? tps_pkg::ST_FINISH
                                                             : tps_pkg::ST_SQRT;
                end
            end
            tps_pkg::ST_SQRT: begin
                if (sq_res.done) state_next = tps_pkg::ST_DIV_PER;
            end
            tps_pkg::ST_DIV_PER: begin
                if (div_res.done) begin
                    state_next = ({1'b0, div_res.quotient} > CNT_MAX)
                               ? tps_pkg::ST_DIV_CEIL : tps_pkg::ST_FINISH;
                end
            end
            tps_pkg::ST_DIV_CEIL: begin
                if (div_res.done) state_next = tps_pkg::ST_DIV_PER2;
            end
            tps_pkg::ST_DIV_PER2: begin
                if (div_res.done) state_next = tps_pkg::ST_FINISH;
            end
            tps_pkg::ST_FINISH: begin
                if (out_free) state_next = tps_pkg::ST_IDLE;
            end
            default: state_next = tps_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        total_next   = total_reg;
        pre_next     = pre_reg;
        per_next     = per_reg;
        stat_next    = stat_reg;
        m_pre_next   = m_pre_reg;
        m_rel_next   = m_rel_reg;
        m_stat_next  = m_stat_reg;
        m_valid_next = m_valid_reg && !m_tready;
        div_start    = 1'b0;
        div_a        = total_reg;
        div_b        = pre_reg;
        sq_start     = 1'b0;
        unique case (state_reg)
            tps_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    stat_next = tps_pkg::STATUS_OK;
                    if (s_tdata == 32'd0) begin
                        stat_next = tps_pkg::STATUS_ZERO;
                    end else begin
                        div_start = 1'b1;
                        div_a     = clk_freq_reg;
                        div_b     = s_tdata;
                    end
                end
            end
            tps_pkg::ST_DIV_TOTAL: begin
                if (div_res.done) begin
                    total_next = div_res.quotient;
                    if (div_res.quotient == 32'd0) begin
                        stat_next = tps_pkg::STATUS_TOO_HIGH;
                    end else begin
                        sq_start = 1'b1;
                    end
                end
            end
            tps_pkg::ST_SQRT: begin
                if (sq_res.done) begin
                    pre_next  = root_clamp;
                    div_start = 1'b1;
                    div_b     = root_clamp;
                end
            end
            tps_pkg::ST_DIV_PER: begin
                if (div_res.done) begin
                    per_next = div_res.quotient;
                    if ({1'b0, div_res.quotient} > CNT_MAX) begin
                        // period overflows: prescaler = ceil(total / CNT_MAX)
                        div_start = 1'b1;
                        div_b     = CNT_MAX[31:0];
                    end
                end
            end
            tps_pkg::ST_DIV_CEIL: begin
                if (div_res.done) begin
                    pre_next  = ceil_q;
                    div_start = 1'b1;
                    div_b     = ceil_q;
                end
            end
            tps_pkg::ST_DIV_PER2: begin
                if (div_res.done) per_next = div_res.quotient;
            end
            tps_pkg::ST_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_pre_next   = 16'd0;
                    m_rel_next   = 16'd0;
                    m_stat_next  = stat_reg;
                    if (stat_reg == tps_pkg::STATUS_OK) begin
                        if ({1'b0, pre_reg} > CNT_MAX || {1'b0, per_fix} > CNT_MAX) begin
                            m_stat_next = tps_pkg::STATUS_NO_SPLIT;
                        end else begin
                            m_pre_next = pre_m1[15:0];
                            m_rel_next = per_m1[15:0];
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= tps_pkg::ST_IDLE;
            m_valid_reg  <= 1'b0;
            clk_freq_reg <= 32'd0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) clk_freq_reg <= cfg_wr_data;
        end
        total_reg  <= total_next;
        pre_reg    <= pre_next;
        per_reg    <= per_next;
        stat_reg   <= stat_next;
        m_pre_reg  <= m_pre_next;
        m_rel_reg  <= m_rel_next;
        m_stat_reg <= m_stat_next;
    end

    assign s_tready = (state_reg == tps_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_rel_reg, m_pre_reg};
    assign m_tuser  = m_stat_reg;

endmodule
`default_nettype wire

// File: sv/tps_checker.sv
// Port-level checker for the splitter top level, bound in below.
// Depends on tps_pkg and timer_prescaler_period_split_top.
`timescale 1ns / 1ps
`default_nettype none
module tps_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        cfg_wr_en,
    input wire logic [31:0] cfg_wr_data,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [31:0] s_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    // a held result stays up until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped before it was taken");

    // any error status carries zero register values
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != tps_pkg::STATUS_OK) |-> (m_tdata == 32'd0))
        else $error("error result with nonzero register values");

    // an accepted request keeps the input closed while it is worked on
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while another is in flight");

    // reset empties the output and opens the input
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("bad state after reset");

endmodule

bind timer_prescaler_period_split_top tps_checker u_tps_checker (.*);
`default_nettype wire
